// ===== rtl/core/ttsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Tape tone filter package
// Shared types, register map, multiplier modes and shaper coefficients.
// ----------------------------------------------------------------------------
package ttsf_pkg;

  localparam int SAMPLE_BITS = 24;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } result_t;

  // Register map, one word apart.
  localparam logic [2:0] REG_INPUT_GAIN   = 3'd0;
  localparam logic [2:0] REG_SOFTEN       = 3'd1;
  localparam logic [2:0] REG_ROLL_COEFF   = 3'd2;
  localparam logic [2:0] REG_CASCADE      = 3'd3;
  localparam logic [2:0] REG_OUTPUT_GAIN  = 3'd4;
  localparam logic [2:0] REG_WET_MIX      = 3'd5;

  localparam logic [16:0] UNITY_Q16 = 17'd65536;

  // Coefficients as the lanes see them, already limited to 1.0 where needed.
  typedef struct packed {
    logic [17:0] input_gain;
    logic [16:0] roll;
    logic [26:0] cascade;
    logic [17:0] output_gain;
    logic [16:0] wet;
  } coef_t;

  // Product scaling of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_RND16 = 2'd0,
    MUL_RND32 = 2'd1,
    MUL_RND33 = 2'd2,
    MUL_FLR30 = 2'd3
  } mul_mode_t;

  typedef struct packed {
    logic      start;
    mul_mode_t mode;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic done;
  } lane_stat_t;

  // Horner coefficients of 1-cos(pi/2*sqrt(z))/z, Q30, lowest order first.
  localparam logic signed [31:0] SHAPER_POLY [6] = '{
    32'sd1324675879, -32'sd272375560, 32'sd22401992,
    -32'sd987049, 32'sd27061, -32'sd506
  };

  localparam logic [31:0] SEED_LEFT  = 32'h2463534A;
  localparam logic [31:0] SEED_RIGHT = 32'h5EED1234;

  function automatic logic [31:0] xorshift(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    a = v ^ (v << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

// ===== rtl/core/ttsf_mul.sv =====
// ----------------------------------------------------------------------------
// Tape tone filter multiplier
// Signed state word times unsigned coefficient in two half-width partial
// products, then rounding or flooring, scaling and saturation.
// ----------------------------------------------------------------------------
module ttsf_mul #(
  parameter int STATE_BITS = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ttsf_pkg::mul_req_t           req,
  input  logic signed [STATE_BITS-1:0] a,
  input  logic [32:0]                  b,
  output logic                         done,
  output logic signed [STATE_BITS-1:0] q
);

  localparam int SB = STATE_BITS;
  localparam int H  = (SB + 1) / 2;
  localparam int HL = SB - H;
  localparam int PW = SB + 33;
  localparam logic [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SNEG = {1'b1, {(SB-1){1'b0}}};

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_LO   = 5'b00010,
    M_HI   = 5'b00100,
    M_SUM  = 5'b01000,
    M_OUT  = 5'b10000
  } mstate_t;

  mstate_t             st;
  logic                neg;
  logic [SB-1:0]       mag;
  logic [32:0]         bq;
  ttsf_pkg::mul_mode_t mode;
  logic [H+32:0]       plo;
  logic [HL+32:0]      phi;
  logic [PW-1:0]       prod;
  logic [PW-1:0]       addend;
  logic [PW-1:0]       shifted;
  logic [SB-1:0]       limit;
  logic [SB-1:0]       capped;

  always_comb begin
    unique case (mode)
      ttsf_pkg::MUL_RND16: begin
        addend  = PW'(1) << 15;
        shifted = prod >> 16;
      end
      ttsf_pkg::MUL_RND32: begin
        addend  = PW'(1) << 31;
        shifted = prod >> 32;
      end
      ttsf_pkg::MUL_RND33: begin
        addend  = PW'(1) << 32;
        shifted = prod >> 33;
      end
      ttsf_pkg::MUL_FLR30: begin
        // Flooring a negative product rounds its magnitude up.
        addend  = neg ? ((PW'(1) << 30) - PW'(1)) : '0;
        shifted = prod >> 30;
      end
    endcase
    // A negative result may reach one step further than a positive one.
    limit  = neg ? SNEG : SMAX;
    capped = (shifted > PW'(limit)) ? limit : shifted[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= M_IDLE;
      done <= 1'b0;
      neg  <= 1'b0;
      mode <= ttsf_pkg::MUL_RND16;
    end else begin
      done <= 1'b0;
      unique case (st)
        M_IDLE: begin
          if (req.start) begin
            neg  <= a[SB-1];
            mag  <= a[SB-1] ? SB'(~a + 1'b1) : SB'(a);
            bq   <= b;
            mode <= req.mode;
            st   <= M_LO;
          end
        end
        M_LO: begin
          plo <= (H+33)'(mag[H-1:0]) * (H+33)'(bq);
          st  <= M_HI;
        end
        M_HI: begin
          phi <= (HL+33)'(mag[SB-1:H]) * (HL+33)'(bq);
          st  <= M_SUM;
        end
        M_SUM: begin
          prod <= PW'(plo) + (PW'(phi) << H) + addend;
          st   <= M_OUT;
        end
        M_OUT: begin
          q    <= neg ? $signed(~capped + 1'b1) : $signed(capped);
          done <= 1'b1;
          st   <= M_IDLE;
        end
        default: st <= M_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/ttsf_lane.sv =====
// ----------------------------------------------------------------------------
// Tape tone filter lane
// One channel: input gain, lowpass cascade, roller blend, high shaper,
// output gain, wet/dry mix and output saturation, all on one multiplier.
// ----------------------------------------------------------------------------
module ttsf_lane #(
  parameter int STAGES     = 26,
  parameter int STATE_BITS = 48
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ttsf_pkg::lane_ctrl_t                   ctrl,
  input  logic signed [ttsf_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [1:0]                             sel,
  input  logic [31:0]                            weight,
  input  ttsf_pkg::coef_t                        coef,
  output ttsf_pkg::lane_stat_t                   stat,
  output logic signed [ttsf_pkg::SAMPLE_BITS-1:0] result_sample
);

  localparam int SB   = STATE_BITS;
  localparam int SW   = ttsf_pkg::SAMPLE_BITS;
  localparam int FRAC = SB - 8;
  localparam int G    = SB - SW - 7;
  localparam int SHR  = (FRAC >= 30) ? FRAC - 30 : 0;
  localparam int SHL  = (FRAC >= 30) ? 0 : 30 - FRAC;
  localparam int KW   = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam bit FULL = (SB == 64);
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] ROUND_G = {{(SB-1){1'b0}}, 1'b1} <<< (G - 1);
  localparam logic signed [SB-1:0] OMAX = {{(SB-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [SB-1:0] OMIN = {{(SB-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic [SB-1:0] ONE_F = SB'(1) << FRAC;

  typedef enum logic [27:0] {
    L_IDLE  = 28'd1 << 0,  L_GAIN  = 28'd1 << 1,  L_RD    = 28'd1 << 2,
    L_CALC  = 28'd1 << 3,  L_CWAIT = 28'd1 << 4,  L_CUPD  = 28'd1 << 5,
    L_XSUB  = 28'd1 << 6,  L_ROLL  = 28'd1 << 7,  L_RWAIT = 28'd1 << 8,
    L_DBL   = 28'd1 << 9,  L_BLEND = 28'd1 << 10, L_BWAIT = 28'd1 << 11,
    L_HP    = 28'd1 << 12, L_SH0   = 28'd1 << 13, L_SZ    = 28'd1 << 14,
    L_SPOLY = 28'd1 << 15, L_SPW   = 28'd1 << 16, L_SLAST = 28'd1 << 17,
    L_SLW   = 28'd1 << 18, L_SHEND = 28'd1 << 19, L_SHSUB = 28'd1 << 20,
    L_OGAIN = 28'd1 << 21, L_OGW   = 28'd1 << 22, L_MIX   = 28'd1 << 23,
    L_MIXW  = 28'd1 << 24, L_FIN   = 28'd1 << 25, L_CLAMP = 28'd1 << 26,
    L_DONE  = 28'd1 << 27
  } lstate_t;

  function automatic logic signed [SB-1:0] sat_wide(input logic [SB:0] v);
    if (v[SB] != v[SB-1]) return v[SB] ? SMIN : SMAX;
    return $signed(v[SB-1:0]);
  endfunction

  function automatic logic signed [SB-1:0] sadd(input logic signed [SB-1:0] p,
                                                input logic signed [SB-1:0] r);
    return sat_wide({p[SB-1], p} + {r[SB-1], r});
  endfunction

  // At the full 64-bit width the most negative subtrahend is negated to the
  // largest positive value, one short of its true magnitude.
  function automatic logic signed [SB-1:0] ssub(input logic signed [SB-1:0] p,
                                                input logic signed [SB-1:0] r);
    if (FULL && (r == SMIN)) return sadd(p, SMAX);
    return sat_wide({p[SB-1], p} - {r[SB-1], r});
  endfunction

  lstate_t                state;
  logic [KW-1:0]          k;
  logic [2:0]             j;
  logic signed [SB-1:0]   dry, x, t, sub, s, r, osum, tmp, acc;
  logic signed [SB-1:0]   rl0, rl1, rl2;
  logic [30:0]            z, y;
  logic                   hneg;
  logic signed [SB-1:0]   casc [STAGES];
  logic [STAGES-1:0]      vld;
  logic signed [SB-1:0]   rd_q;
  logic                   rd_vld;

  logic signed [SB-1:0]   dry_in, s_rd, s_new, r_pick, osum_pick, ysh, v_sh;
  logic [SB-1:0]          hmag;
  logic                   big;
  logic [30:0]            x30;

  ttsf_pkg::mul_req_t     mreq;
  logic signed [SB-1:0]   mul_a;
  logic [32:0]            mul_b;
  logic                   mdone;
  logic signed [SB-1:0]   mul_q;

  ttsf_mul #(.STATE_BITS(SB)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .a    (mul_a),
    .b    (mul_b),
    .done (mdone),
    .q    (mul_q)
  );

  assign dry_in = $signed({{(SB-SW){sample[SW-1]}}, sample}) <<< G;
  assign s_rd   = rd_vld ? rd_q : '0;
  assign s_new  = sadd(s, mul_q);
  assign hmag   = tmp[SB-1] ? SB'(~tmp + 1'b1) : SB'(tmp);
  assign big    = (hmag >= ONE_F);
  assign x30    = 31'((hmag >> SHR) << SHL);
  assign ysh    = $signed((SB'(y) << SHR) >> SHL);
  assign v_sh   = x >>> G;
  assign stat.done = (state == L_DONE);

  always_comb begin
    unique case (sel)
      2'd1: begin
        r_pick    = rl1;
        osum_pick = sadd(rl2, rl0);
      end
      2'd2: begin
        r_pick    = rl2;
        osum_pick = sadd(rl0, rl1);
      end
      default: begin
        r_pick    = rl0;
        osum_pick = sadd(rl1, rl2);
      end
    endcase
  end

  always_comb begin
    mreq.start = 1'b0;
    mreq.mode  = ttsf_pkg::MUL_RND16;
    mul_a      = x;
    mul_b      = '0;
    unique case (state)
      L_IDLE: begin
        mreq.start = ctrl.start;
        mul_a      = dry_in;
        mul_b      = 33'(coef.input_gain);
      end
      L_CALC: begin
        mreq.start = 1'b1;
        mreq.mode  = ttsf_pkg::MUL_RND32;
        mul_a      = ssub(t, s_rd);
        mul_b      = 33'(coef.cascade);
      end
      L_ROLL: begin
        mreq.start = 1'b1;
        mul_a      = ssub(x, r);
        mul_b      = 33'(coef.roll);
      end
      L_BLEND: begin
        mreq.start = 1'b1;
        mreq.mode  = ttsf_pkg::MUL_RND33;
        mul_a      = ssub(osum, tmp);
        mul_b      = 33'(weight);
      end
      L_SH0: begin
        mreq.start = !big;
        mreq.mode  = ttsf_pkg::MUL_FLR30;
        mul_a      = SB'(x30);
        mul_b      = 33'(x30);
      end
      L_SPOLY, L_SLAST: begin
        mreq.start = 1'b1;
        mreq.mode  = ttsf_pkg::MUL_FLR30;
        mul_a      = acc;
        mul_b      = 33'(z);
      end
      L_OGAIN: begin
        mreq.start = 1'b1;
        mul_a      = x;
        mul_b      = 33'(coef.output_gain);
      end
      L_MIX: begin
        mreq.start = 1'b1;
        mul_a      = tmp;
        mul_b      = 33'(coef.wet);
      end
      default: begin
        mreq.start = 1'b0;
      end
    endcase
  end

  // Cascade section storage, one read and one write port.
  always_ff @(posedge clk) begin
    if (state == L_RD) begin
      rd_q <= casc[k];
    end
    if ((state == L_CWAIT) && mdone) begin
      casc[k] <= s_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= L_IDLE;
      vld    <= '0;
      rl0    <= '0;
      rl1    <= '0;
      rl2    <= '0;
      rd_vld <= 1'b0;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (ctrl.start) begin
            dry   <= dry_in;
            state <= L_GAIN;
          end
        end
        L_GAIN: begin
          if (mdone) begin
            x     <= mul_q;
            t     <= mul_q;
            sub   <= '0;
            k     <= '0;
            state <= L_RD;
          end
        end
        L_RD: begin
          rd_vld <= vld[k];
          state  <= L_CALC;
        end
        L_CALC: begin
          s     <= s_rd;
          state <= L_CWAIT;
        end
        L_CWAIT: begin
          if (mdone) begin
            s      <= s_new;
            vld[k] <= 1'b1;
            state  <= L_CUPD;
          end
        end
        L_CUPD: begin
          t   <= ssub(t, s);
          sub <= sadd(sub, s);
          if (k == KW'(STAGES - 1)) begin
            state <= L_XSUB;
          end else begin
            k     <= k + 1'b1;
            state <= L_RD;
          end
        end
        L_XSUB: begin
          x     <= ssub(x, sub);
          r     <= r_pick;
          osum  <= osum_pick;
          state <= L_ROLL;
        end
        L_ROLL: state <= L_RWAIT;
        L_RWAIT: begin
          if (mdone) begin
            r     <= sadd(r, mul_q);
            state <= L_DBL;
          end
        end
        L_DBL: begin
          tmp   <= sadd(r, r);
          state <= L_BLEND;
        end
        L_BLEND: state <= L_BWAIT;
        L_BWAIT: begin
          if (mdone) begin
            r     <= sadd(r, mul_q);
            state <= L_HP;
          end
        end
        L_HP: begin
          tmp <= ssub(x, r);
          unique case (sel)
            2'd1:    rl1 <= r;
            2'd2:    rl2 <= r;
            default: rl0 <= r;
          endcase
          state <= L_SH0;
        end
        L_SH0: begin
          hneg <= tmp[SB-1];
          if (big) begin
            y     <= 31'd1 << 30;
            state <= L_SHEND;
          end else begin
            state <= L_SZ;
          end
        end
        L_SZ: begin
          if (mdone) begin
            z     <= mul_q[30:0];
            acc   <= SB'(ttsf_pkg::SHAPER_POLY[5]);
            j     <= 3'd4;
            state <= L_SPOLY;
          end
        end
        L_SPOLY: state <= L_SPW;
        L_SPW: begin
          if (mdone) begin
            acc <= SB'(ttsf_pkg::SHAPER_POLY[j]) + mul_q;
            if (j == 3'd0) begin
              state <= L_SLAST;
            end else begin
              j     <= j - 3'd1;
              state <= L_SPOLY;
            end
          end
        end
        L_SLAST: state <= L_SLW;
        L_SLW: begin
          if (mdone) begin
            y     <= mul_q[SB-1] ? 31'd0 : mul_q[30:0];
            state <= L_SHEND;
          end
        end
        L_SHEND: begin
          tmp   <= hneg ? -ysh : ysh;
          state <= L_SHSUB;
        end
        L_SHSUB: begin
          x     <= ssub(x, tmp);
          state <= L_OGAIN;
        end
        L_OGAIN: state <= L_OGW;
        L_OGW: begin
          if (mdone) begin
            tmp   <= ssub(mul_q, dry);
            state <= L_MIX;
          end
        end
        L_MIX: state <= L_MIXW;
        L_MIXW: begin
          if (mdone) begin
            x     <= sadd(dry, mul_q);
            state <= L_FIN;
          end
        end
        L_FIN: begin
          x     <= sadd(x, ROUND_G);
          state <= L_CLAMP;
        end
        L_CLAMP: begin
          if (v_sh > OMAX) begin
            result_sample <= OMAX[SW-1:0];
          end else if (v_sh < OMIN) begin
            result_sample <= OMIN[SW-1:0];
          end else begin
            result_sample <= v_sh[SW-1:0];
          end
          state <= L_DONE;
        end
        L_DONE: begin
          if (ctrl.ack) begin
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/tape_tone_stereo_filter.sv =====
// ----------------------------------------------------------------------------
// Tape tone stereo filter
// Stereo tape-tone processing with one lane per channel and a merging
// output register.
//
//   channel   direction   handshake                    beat
//   sample    in          sample_valid / sample_stall  one stereo frame
//   result    out         result_valid / result_stall  one processed frame
//   config    in          APB write, psel/penable      one register word
//
// Each lane walks its cascade one section at a time on its own multiplier,
// and the result is loaded sooner when the highs of both channels reach
// full scale and the shaper polynomial is skipped.
// Reset is synchronous; all state is cleared at once, no clearing pass.
// A new frame is taken as soon as both lanes hand their results to the
// output register, even while that register is still stalled.
// ----------------------------------------------------------------------------
module tape_tone_stereo_filter #(
  parameter int STAGES     = 26,
  parameter int STATE_BITS = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  ttsf_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_stall,
  output ttsf_pkg::result_t result
);

  logic [17:0] input_gain;
  logic [16:0] soften_amount;
  logic [16:0] roll_coeff;
  logic [26:0] cascade_coeff;
  logic [17:0] output_gain;
  logic [16:0] wet_mix;

  logic        busy;
  logic [1:0]  phase_counter;
  logic [31:0] noise_left, noise_right;
  logic [1:0]  sel;
  logic [31:0] weight;

  logic        accept, cfg_wr, take;
  logic [1:0]  phase_eff;
  logic [16:0] soft_c;
  logic [48:0] wprod;
  logic [2:0]  reg_idx;

  ttsf_pkg::coef_t      coef;
  ttsf_pkg::lane_ctrl_t lctrl;
  ttsf_pkg::lane_stat_t lstat, rstat;
  logic signed [ttsf_pkg::SAMPLE_BITS-1:0] lres, rres;

  assign pready       = 1'b1;
  assign sample_stall = busy;
  assign accept       = sample_valid && !busy;
  assign cfg_wr       = psel && penable && pwrite;
  assign reg_idx      = paddr[4:2];

  assign soft_c    = (soften_amount > ttsf_pkg::UNITY_Q16) ? ttsf_pkg::UNITY_Q16 : soften_amount;
  assign wprod     = 49'(noise_left) * 49'(soft_c);
  // A cleared phase counter behaves as phase one.
  assign phase_eff = (phase_counter == 2'd0) ? 2'd1 : phase_counter;

  assign coef.input_gain  = input_gain;
  assign coef.roll        = (roll_coeff > ttsf_pkg::UNITY_Q16) ? ttsf_pkg::UNITY_Q16 : roll_coeff;
  assign coef.cascade     = cascade_coeff;
  assign coef.output_gain = output_gain;
  assign coef.wet         = (wet_mix > ttsf_pkg::UNITY_Q16) ? ttsf_pkg::UNITY_Q16 : wet_mix;

  assign take        = lstat.done && rstat.done && (!result_valid || !result_stall);
  assign lctrl.start = accept;
  assign lctrl.ack   = take;

  ttsf_lane #(.STAGES(STAGES), .STATE_BITS(STATE_BITS)) u_lane_left (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (lctrl),
    .sample        (sample.left_sample),
    .sel           (sel),
    .weight        (weight),
    .coef          (coef),
    .stat          (lstat),
    .result_sample (lres)
  );

  ttsf_lane #(.STAGES(STAGES), .STATE_BITS(STATE_BITS)) u_lane_right (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (lctrl),
    .sample        (sample.right_sample),
    .sel           (sel),
    .weight        (weight),
    .coef          (coef),
    .stat          (rstat),
    .result_sample (rres)
  );

  always_comb begin
    unique case (reg_idx)
      ttsf_pkg::REG_INPUT_GAIN:  prdata = 32'(input_gain);
      ttsf_pkg::REG_SOFTEN:      prdata = 32'(soften_amount);
      ttsf_pkg::REG_ROLL_COEFF:  prdata = 32'(roll_coeff);
      ttsf_pkg::REG_CASCADE:     prdata = 32'(cascade_coeff);
      ttsf_pkg::REG_OUTPUT_GAIN: prdata = 32'(output_gain);
      ttsf_pkg::REG_WET_MIX:     prdata = 32'(wet_mix);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain    <= 18'd65536;
      soften_amount <= 17'd0;
      roll_coeff    <= 17'd65536;
      cascade_coeff <= 27'd17179869;
      output_gain   <= 18'd65536;
      wet_mix       <= 17'd65536;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ttsf_pkg::REG_INPUT_GAIN:  input_gain    <= pwdata[17:0];
        ttsf_pkg::REG_SOFTEN:      soften_amount <= pwdata[16:0];
        ttsf_pkg::REG_ROLL_COEFF:  roll_coeff    <= pwdata[16:0];
        ttsf_pkg::REG_CASCADE:     cascade_coeff <= pwdata[26:0];
        ttsf_pkg::REG_OUTPUT_GAIN: output_gain   <= pwdata[17:0];
        ttsf_pkg::REG_WET_MIX:     wet_mix       <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      phase_counter <= 2'd1;
      noise_left    <= ttsf_pkg::SEED_LEFT;
      noise_right   <= ttsf_pkg::SEED_RIGHT;
      result_valid  <= 1'b0;
    end else begin
      if (accept) begin
        busy          <= 1'b1;
        sel           <= phase_eff - 2'd1;
        // The blend weight uses the left noise word from before this frame.
        weight        <= wprod[47:16];
        phase_counter <= phase_eff + 2'd1;
        noise_left    <= ttsf_pkg::xorshift(noise_left);
        noise_right   <= ttsf_pkg::xorshift(noise_right);
      end
      if (take) begin
        busy            <= 1'b0;
        result_valid    <= 1'b1;
        result.left_out <= lres;
        result.right_out <= rres;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall)
    else $error("frame accepted without the block turning busy");

  a_result_from_both_lanes: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(lstat.done && rstat.done))
    else $error("result loaded before both lanes finished");

  a_lanes_idle_when_free: assert property (@(posedge clk) disable iff (rst)
    !sample_stall |-> (!lstat.done && !rstat.done))
    else $error("lane holds a result while the block takes new frames");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Tape tone stereo filter testbench
// Drives stereo frames through the filter under several register settings,
// with random gaps and output stalls, and checks every processed frame
// against a bit-exact fixed-point predictor of both channels, or against a fixed frame where one is given.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NSEC       = 26;
  localparam int  FRAC       = 40;
  localparam int  GUARD      = 17;
  localparam int  IDLE_LIMIT = 20000;
  localparam longint S_MAX   = (64'sd1 <<< 47) - 1;
  localparam longint S_MIN   = -(64'sd1 <<< 47);
  localparam longint SAMP_MAX = 64'sd8388607;
  localparam longint SAMP_MIN = -64'sd8388608;

  localparam longint HORNER [6] = '{
    64'sd1324675879, -64'sd272375560, 64'sd22401992,
    -64'sd987049, 64'sd27061, -64'sd506
  };

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    psel = 1'b0;
  logic    penable = 1'b0;
  logic    pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic    pready;
  logic    sample_valid = 1'b0;
  logic    sample_stall;
  ttsf_pkg::sample_t sample = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  ttsf_pkg::result_t result;

  tape_tone_stereo_filter dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #10 clk = ~clk;

  // Predictor copy of registers and filter state.
  logic [26:0] reg_val [6];
  longint      section_st [2*NSEC];
  longint      roller_st [6];
  int          phase;
  logic [31:0] noise_l, noise_r;

  ttsf_pkg::result_t frame_q [$];
  int      errors = 0;
  bit      quiet = 1'b0;
  int      idle_cycles = 0;

  function automatic longint clamp48(longint v);
    return v > S_MAX ? S_MAX : (v < S_MIN ? S_MIN : v);
  endfunction

  // (a*b)/2^sh rounded half away from zero, then limited to 48 bits.
  function automatic longint scale_mul(longint a, logic [63:0] b, int sh);
    logic [127:0] p;
    logic [63:0]  m;
    longint       r;
    m = (a < 0) ? -a : a;
    p = {64'd0, m} * {64'd0, b};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > 128'h7FFF_FFFF_FFFF_FFFF) r = 64'sh7FFF_FFFF_FFFF_FFFF;
    else r = p[63:0];
    return clamp48(a < 0 ? -r : r);
  endfunction

  function automatic longint soft_clip(longint h);
    longint m, x, z, acc, y;
    m = (h < 0) ? -h : h;
    if (m >= (64'sd1 <<< FRAC)) begin
      y = 64'sd1 <<< 30;
    end else begin
      x = m >>> (FRAC - 30);
      z = (x * x) >>> 30;
      acc = HORNER[5];
      for (int k = 4; k >= 0; k--) acc = HORNER[k] + ((acc * z) >>> 30);
      y = (acc * z) >>> 30;
      if (y < 0) y = 0;
    end
    y = clamp48(y <<< (FRAC - 30));
    return h > 0 ? y : (h < 0 ? -y : 64'sd0);
  endfunction

  function automatic longint tone_channel(int ch, longint dry, int sel,
                                          logic [63:0] w);
    longint roll, wet, x, t, sub, o1, o2, r;
    roll = reg_val[ttsf_pkg::REG_ROLL_COEFF] > 65536 ? 65536
                                                      : reg_val[ttsf_pkg::REG_ROLL_COEFF];
    wet  = reg_val[ttsf_pkg::REG_WET_MIX] > 65536 ? 65536 : reg_val[ttsf_pkg::REG_WET_MIX];
    x = scale_mul(dry, reg_val[ttsf_pkg::REG_INPUT_GAIN], 16);
    t = x;
    sub = 0;
    for (int k = 0; k < NSEC; k++) begin
      section_st[ch*NSEC+k] = clamp48(section_st[ch*NSEC+k] +
          scale_mul(clamp48(t - section_st[ch*NSEC+k]), reg_val[ttsf_pkg::REG_CASCADE], 32));
      t = clamp48(t - section_st[ch*NSEC+k]);
      sub = clamp48(sub + section_st[ch*NSEC+k]);
    end
    x = clamp48(x - sub);
    o1 = roller_st[ch*3 + (sel+1) % 3];
    o2 = roller_st[ch*3 + (sel+2) % 3];
    r = roller_st[ch*3 + sel];
    r = clamp48(r + scale_mul(clamp48(x - r), roll, 16));
    r = clamp48(r + scale_mul(clamp48(clamp48(o1 + o2) - clamp48(r + r)), w, 33));
    roller_st[ch*3 + sel] = r;
    x = clamp48(x - soft_clip(clamp48(x - r)));
    x = scale_mul(x, reg_val[ttsf_pkg::REG_OUTPUT_GAIN], 16);
    return clamp48(dry + scale_mul(clamp48(x - dry), wet, 16));
  endfunction

  function automatic logic [23:0] to_q23(longint v);
    longint s;
    s = clamp48(v + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
    if (s > SAMP_MAX) s = SAMP_MAX;
    if (s < SAMP_MIN) s = SAMP_MIN;
    return s[23:0];
  endfunction

  function automatic logic [31:0] next_noise(logic [31:0] v);
    v = v ^ (v << 13);
    v = v ^ (v >> 17);
    return v ^ (v << 5);
  endfunction

  function automatic ttsf_pkg::result_t filter_frame(ttsf_pkg::sample_t s);
    ttsf_pkg::result_t o;
    logic [63:0] w;
    longint      soften;
    int          sel;
    soften = reg_val[ttsf_pkg::REG_SOFTEN] > 65536 ? 65536 : reg_val[ttsf_pkg::REG_SOFTEN];
    w = ({32'd0, noise_l} * soften) >> 16;
    if (phase < 1 || phase > 3) phase = 1;
    sel = phase - 1;
    o.left_out  = to_q23(tone_channel(0, longint'(s.left_sample) <<< GUARD, sel, w));
    o.right_out = to_q23(tone_channel(1, longint'(s.right_sample) <<< GUARD, sel, w));
    phase = (phase + 1) & 3;
    noise_l = next_noise(noise_l);
    noise_r = next_noise(noise_r);
    return o;
  endfunction

  task automatic predictor_reset();
    foreach (section_st[i]) section_st[i] = 0;
    foreach (roller_st[i]) roller_st[i] = 0;
    reg_val[ttsf_pkg::REG_INPUT_GAIN] = 65536;
    reg_val[ttsf_pkg::REG_SOFTEN] = 0;
    reg_val[ttsf_pkg::REG_ROLL_COEFF] = 65536;
    reg_val[ttsf_pkg::REG_CASCADE] = 17179869;
    reg_val[ttsf_pkg::REG_OUTPUT_GAIN] = 65536;
    reg_val[ttsf_pkg::REG_WET_MIX] = 65536;
    phase = 1;
    noise_l = 32'h2463534A;
    noise_r = 32'h5EED1234;
  endtask

  task automatic write_reg(int idx, logic [31:0] value);
    int width [6] = '{18, 17, 17, 27, 18, 17};
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx < 6) reg_val[idx] = 27'(value & ((32'd1 << width[idx]) - 1));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [23:0] random_q23();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      1, 2, 3: return 24'($signed($urandom_range(0, 8191)) - 4096);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_frame(ttsf_pkg::sample_t s, bit has_fixed,
                            ttsf_pkg::result_t fixed_out);
    int      gap;
    ttsf_pkg::result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      sample_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    pred = filter_frame(s);
    frame_q.push_back(has_fixed ? fixed_out : pred);
  endtask

  task automatic drain();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
  endtask

  // Output stall pattern, bursty with occasional long holds.
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < 15) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(0, 3);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h/%h", $time,
                 result.left_out, result.right_out);
        errors++;
      end else begin
        if (result.left_out !== frame_q[0].left_out) begin
          $display("%0t: left_out expected %h actual %h", $time,
                   frame_q[0].left_out, result.left_out);
          errors++;
        end
        if (result.right_out !== frame_q[0].right_out) begin
          $display("%0t: right_out expected %h actual %h", $time,
                   frame_q[0].right_out, result.right_out);
          errors++;
        end
        void'(frame_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  typedef struct {
    logic [23:0] l;
    logic [23:0] r;
    bit          fixed;
  } frame_row_t;

  // Silence after reset leaves every state at zero, so the output is zero.
  frame_row_t directed [20] = '{
    '{24'h000000, 24'h000000, 1}, '{24'h000000, 24'h000000, 1},
    '{24'h000000, 24'h000000, 1},
    '{24'h7FFFFF, 24'h7FFFFF, 0}, '{24'h800000, 24'h800000, 0},
    '{24'h7FFFFF, 24'h800000, 0}, '{24'h800000, 24'h7FFFFF, 0},
    '{24'h000001, 24'hFFFFFF, 0}, '{24'hFFFFFF, 24'h000001, 0},
    '{24'h400000, 24'hC00000, 0}, '{24'h555555, 24'hAAAAAA, 0},
    '{24'hAAAAAA, 24'h555555, 0}, '{24'h7FFFFF, 24'h000000, 0},
    '{24'h000000, 24'h800000, 0}, '{24'h123456, 24'hEDCBA9, 0},
    '{24'h7FFFFF, 24'h7FFFFF, 0}, '{24'h7FFFFF, 24'h7FFFFF, 0},
    '{24'h800000, 24'h800000, 0}, '{24'h000000, 24'h000000, 0},
    '{24'h0F0F0F, 24'hF0F0F0, 0}
  };

  logic [31:0] setting [6];

  initial begin
    ttsf_pkg::sample_t s;
    ttsf_pkg::result_t zero_out;
    zero_out = '0;
    predictor_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      s.left_sample = directed[i].l;
      s.right_sample = directed[i].r;
      send_frame(s, directed[i].fixed, zero_out);
    end
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: setting = '{131072, 65536, 65536, 67108864, 131072, 65536};
        1: setting = '{0, 0, 0, 0, 0, 0};
        2: setting = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                       32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        3: setting = '{65536, 0, 65536, 17179869, 65536, 65536};
        default: begin
          setting[ttsf_pkg::REG_INPUT_GAIN] = $urandom_range(0, 140000);
          setting[ttsf_pkg::REG_SOFTEN] = $urandom_range(0, 70000);
          setting[ttsf_pkg::REG_ROLL_COEFF] = $urandom_range(0, 70000);
          setting[ttsf_pkg::REG_CASCADE] = $urandom_range(0, 3) == 0
                                           ? $urandom_range(0, 67108864)
                                           : $urandom_range(0, 200000);
          setting[ttsf_pkg::REG_OUTPUT_GAIN] = $urandom_range(0, 140000);
          setting[ttsf_pkg::REG_WET_MIX] = $urandom_range(0, 70000);
        end
      endcase
      quiet = (ph == 5);
      for (int k = 0; k < 6; k++) write_reg(k, setting[k]);
      write_reg(6 + (ph & 1), $urandom);
      for (int n = 0; n < (ph < 4 ? 60 : 100); n++) begin
        s.left_sample = random_q23();
        s.right_sample = random_q23();
        send_frame(s, 1'b0, zero_out);
      end
      drain();
    end

    quiet = 1'b0;
    repeat (400) @(posedge clk);
    if (errors == 0 && frame_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ttsf_pkg.sv
rtl/core/ttsf_mul.sv
rtl/core/ttsf_lane.sv
rtl/core/tape_tone_stereo_filter.sv
tb/sv/testbench.sv
